/* rtl/core/eau_pkg.sv */
// Package: beat types, character codes and hex digit helper for the escape decoder.
`timescale 1ns / 1ps

package eau_pkg;

   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_LOWER_N   = 8'h6E;
   localparam logic [7:0] CHAR_LOWER_R   = 8'h72;
   localparam logic [7:0] CHAR_LOWER_T   = 8'h74;
   localparam logic [7:0] CHAR_LOWER_X   = 8'h78;
   localparam logic [7:0] CHAR_UPPER_X   = 8'h58;
   localparam logic [7:0] CHAR_DIGIT_0   = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_9   = 8'h39;
   localparam logic [7:0] CHAR_LOWER_A   = 8'h61;
   localparam logic [7:0] CHAR_LOWER_F   = 8'h66;
   localparam logic [7:0] CHAR_UPPER_A   = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F   = 8'h46;
   localparam logic [7:0] BYTE_NEWLINE   = 8'h0A;
   localparam logic [7:0] BYTE_RETURN    = 8'h0D;
   localparam logic [7:0] BYTE_TAB       = 8'h09;
   localparam logic [7:0] HEX_TEN        = 8'd10;

   typedef struct packed {
      logic [7:0] char_in;
      logic       last_of_string;
   } req_type;

   typedef struct packed {
      logic [7:0] byte_out;
      logic       has_byte;
      logic       bad_hex;
      logic       end_of_string;
   } rsp_type;

   // Bit 4 set: not a hex digit.
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [7:0] d;
      d = 8'd0;
      hex_value = 5'h10;
      if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
         d = c - CHAR_DIGIT_0;
         hex_value = {1'b0, d[3:0]};
      end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) begin
         d = c - CHAR_LOWER_A + HEX_TEN;
         hex_value = {1'b0, d[3:0]};
      end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
         d = c - CHAR_UPPER_A + HEX_TEN;
         hex_value = {1'b0, d[3:0]};
      end
   endfunction

endpackage

/* rtl/core/escaped_ascii_unescaper.sv */
// Top level: backslash escape decoder with hex escapes, one character per beat.
//
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_ready | eau_pkg::req_type (char_in, last_of_string)
//   rsp     | out       | rsp_valid/rsp_ready | eau_pkg::rsp_type (byte_out, has_byte,
//           |           |                     |   bad_hex, end_of_string)
//
// One character per cycle sustained while the rsp side keeps up; a taken beat is held in the
// input register, decoded there, and its result is captured in the result register.
// A character that only opens or continues an escape gives no result beat unless it is last.
// Synchronous reset returns the escape state to plain text and empties the input register,
// the result register and the skid entry. A stalled rsp side fills the skid entry, then holds req_ready low.
`timescale 1ns / 1ps

module escaped_ascii_unescaper (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  eau_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output eau_pkg::rsp_type  rsp_data
);

   logic             push_valid, push_ready;
   eau_pkg::rsp_type push_data;

   eau_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   eau_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

/* rtl/core/eau_decode.sv */
// Input register, escape state and per-character decode logic.
`timescale 1ns / 1ps

module eau_decode (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  eau_pkg::req_type  req_data,
   output logic              push_valid,
   input  logic              push_ready,
   output eau_pkg::rsp_type  push_data
);

   typedef enum logic [1:0] {
      MODE_PLAIN,
      MODE_ESCAPE,
      MODE_HEX_HIGH,
      MODE_HEX_LOW
   } mode_type;

   logic             in_valid_ff;
   eau_pkg::req_type in_data_ff;
   mode_type         mode_ff, mode_in;
   logic [3:0]       nibble_ff, nibble_in;
   logic             aborted_ff, aborted_in;
   logic             emit, bad, has_result, advance;
   logic [7:0]       byte_val;
   logic [4:0]       hex;
   logic [7:0]       c;
   logic             last;

   assign c    = in_data_ff.char_in;
   assign last = in_data_ff.last_of_string;
   assign hex  = eau_pkg::hex_value(c);

   always_comb begin
      mode_in    = mode_ff;
      nibble_in  = nibble_ff;
      aborted_in = aborted_ff;
      emit       = 1'b0;
      bad        = 1'b0;
      byte_val   = 8'd0;
      if (!aborted_ff) begin
         unique case (mode_ff)
            MODE_PLAIN: begin
               if (c == eau_pkg::CHAR_BACKSLASH) begin
                  mode_in = MODE_ESCAPE;
               end else begin
                  emit     = 1'b1;
                  byte_val = c;
               end
            end
            MODE_ESCAPE: begin
               mode_in = MODE_PLAIN;
               emit    = 1'b1;
               priority if (c == eau_pkg::CHAR_LOWER_N) begin
                  byte_val = eau_pkg::BYTE_NEWLINE;
               end else if (c == eau_pkg::CHAR_LOWER_R) begin
                  byte_val = eau_pkg::BYTE_RETURN;
               end else if (c == eau_pkg::CHAR_LOWER_T) begin
                  byte_val = eau_pkg::BYTE_TAB;
               end else if (c == eau_pkg::CHAR_LOWER_X || c == eau_pkg::CHAR_UPPER_X) begin
                  emit    = 1'b0;
                  mode_in = MODE_HEX_HIGH;
               end else begin
                  byte_val = c;
               end
            end
            MODE_HEX_HIGH: begin
               if (!hex[4]) begin
                  nibble_in = hex[3:0];
                  mode_in   = MODE_HEX_LOW;
               end else begin
                  bad = 1'b1;
               end
            end
            MODE_HEX_LOW: begin
               if (!hex[4]) begin
                  emit     = 1'b1;
                  byte_val = {nibble_ff, hex[3:0]};
                  mode_in  = MODE_PLAIN;
               end else begin
                  bad = 1'b1;
               end
            end
            default: begin
               mode_in = MODE_PLAIN;
            end
         endcase
         if (bad) begin
            aborted_in = 1'b1;
            mode_in    = MODE_PLAIN;
            nibble_in  = 4'd0;
         end
      end
      if (last) begin
         mode_in    = MODE_PLAIN;
         nibble_in  = 4'd0;
         aborted_in = 1'b0;
      end
   end

   assign has_result = emit || bad || last;
   assign advance    = in_valid_ff && (!has_result || push_ready);
   assign req_ready  = !in_valid_ff || advance;
   assign push_valid = in_valid_ff && has_result;

   assign push_data.byte_out      = emit ? byte_val : 8'd0;
   assign push_data.has_byte      = emit;
   assign push_data.bad_hex       = bad;
   assign push_data.end_of_string = last;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         mode_ff     <= MODE_PLAIN;
         nibble_ff   <= 4'd0;
         aborted_ff  <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            mode_ff    <= mode_in;
            nibble_ff  <= nibble_in;
            aborted_ff <= aborted_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
   end

endmodule

/* rtl/core/eau_out_stage.sv */
// Result register with skid entry for the response channel.
`timescale 1ns / 1ps

module eau_out_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  eau_pkg::rsp_type  push_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output eau_pkg::rsp_type  rsp_data
);

   logic             main_valid_ff, skid_valid_ff;
   eau_pkg::rsp_type main_data_ff, skid_data_ff;
   logic             pop, push;

   assign pop        = main_valid_ff && rsp_ready;
   assign push_ready = !skid_valid_ff;
   assign push       = push_valid && push_ready;
   assign rsp_valid  = main_valid_ff;
   assign rsp_data   = main_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (skid_valid_ff) begin
            if (pop) begin
               skid_valid_ff <= 1'b0;
            end
         end else if (push) begin
            if (!main_valid_ff || pop) begin
               main_valid_ff <= 1'b1;
            end else begin
               skid_valid_ff <= 1'b1;
            end
         end else if (pop) begin
            main_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            main_data_ff <= skid_data_ff;
         end
      end else if (push) begin
         if (!main_valid_ff || pop) begin
            main_data_ff <= push_data;
         end else begin
            skid_data_ff <= push_data;
         end
      end
   end

endmodule

/* rtl/core/eau_checker.sv */
// Port checker for the escape decoder and its bind to the top level.
`timescale 1ns / 1ps

module eau_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input eau_pkg::rsp_type  rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp beat dropped or changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not empty after reset");

   a_byte_or_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.has_byte && rsp_data.bad_hex))
      else $error("result carries both a byte and a hex error");

   a_empty_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.has_byte |-> rsp_data.byte_out == 8'd0)
      else $error("byte_out not zero without a byte");

   a_result_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.has_byte || rsp_data.bad_hex || rsp_data.end_of_string)
      else $error("result beat without content");

endmodule

bind escaped_ascii_unescaper eau_checker u_eau_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
